[design/sorted_priority_queue_defines.svh]
// Assertion macros shared by the sorted priority queue RTL.
// Expects clk and rst in the scope of each use.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Condition that holds at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/spq_pkg.sv]
// Package for the sorted priority queue: payload types, cell control, codes.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int SPQ_CAPACITY    = 16;
  localparam int SPQ_VALUE_WIDTH = 16;

  localparam int FIELD_VALUE_W = 16;
  localparam int FIELD_COUNT_W = 5;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                     req_type;
    logic [FIELD_VALUE_W-1:0] in_value;
  } spq_req_t;

  typedef struct packed {
    logic [FIELD_VALUE_W-1:0] out_value;
    logic                     out_valid;
    logic [1:0]               status;
    logic [FIELD_COUNT_W-1:0] item_count;
  } spq_rsp_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_op_t;

endpackage

[design/sorted_priority_queue.sv]
// Sorted minimum priority queue: a chain of compare-and-shift cells.
// Has the top-level result register and element count.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_defines.svh.
//
// Usage:
//   req channel (req_valid/req_ready, req): req_type selects enqueue of
//   in_value or dequeue of the smallest stored value.
//   rsp channel (rsp_valid/rsp_ready, rsp): one item per request with the
//   dequeued value, status and the element count after the request.
// Every cell compares the broadcast value with its own and either keeps,
// takes the new value, or takes its neighbor's value, all at the same clock edge.
// The response is registered: it is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the receiver takes each response; the single compare in each cell sets it.
// A full queue drops an enqueue (status full), an empty queue flags a dequeue
// (status empty); neither changes the stored contents.
// Reset clears every valid bit and the count; the queue is empty at once.
// req_ready stays low while rst is high.
// When the receiver stalls, the response register holds its item and
// req_ready drops until the item is taken.
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
  parameter int CAPACITY    = spq_pkg::SPQ_CAPACITY,
  parameter int VALUE_WIDTH = spq_pkg::SPQ_VALUE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  spq_pkg::spq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output spq_pkg::spq_rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VW    = spq_pkg::FIELD_VALUE_W;
  localparam int XW    = (VALUE_WIDTH > VW) ? VALUE_WIDTH : VW;
  localparam int CW    = spq_pkg::FIELD_COUNT_W;
  localparam int EW    = (CNT_W > CW) ? CNT_W : CW;

  logic [VALUE_WIDTH-1:0] val [CAPACITY];
  logic [CAPACITY-1:0]    vld;
  logic [CAPACITY-1:0]    tk;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  logic             enq_ok;
  logic             deq_ok;
  spq_pkg::spq_op_t op;

  logic [XW-1:0]          in_ext;
  logic [VALUE_WIDTH-1:0] new_value;
  logic [XW-1:0]          head_ext;
  logic [EW-1:0]          cnt_ext;
  spq_pkg::spq_rsp_t      rsp_next;

  assign req_ready = !rst && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign is_empty  = (count == '0);
  assign enq_ok    = accept && (req.req_type == spq_pkg::REQ_ENQ) && !is_full;
  assign deq_ok    = accept && (req.req_type == spq_pkg::REQ_DEQ) && !is_empty;
  assign op.enq    = enq_ok;
  assign op.deq    = deq_ok;

  // Mask or widen the input value to the stored width.
  assign in_ext    = XW'(req.in_value);
  assign new_value = in_ext[VALUE_WIDTH-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] lv;
    logic                   lvld;
    logic                   ltk;
    logic [VALUE_WIDTH-1:0] rv;
    logic                   rvld;

    if (i == 0) begin : g_first
      assign lv   = new_value;
      assign lvld = 1'b0;
      assign ltk  = 1'b0;
    end else begin : g_mid_l
      assign lv   = val[i-1];
      assign lvld = vld[i-1];
      assign ltk  = tk[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv   = new_value;
      assign rvld = 1'b0;
    end else begin : g_mid_r
      assign rv   = val[i+1];
      assign rvld = vld[i+1];
    end

    spq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .new_value  (new_value),
      .left_value (lv),
      .left_valid (lvld),
      .left_take  (ltk),
      .right_value(rv),
      .right_valid(rvld),
      .value      (val[i]),
      .valid      (vld[i]),
      .take       (tk[i])
    );
  end

  always_comb begin
    count_next = count;
    if (enq_ok) begin
      count_next = count + CNT_W'(1);
    end else if (deq_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign head_ext = XW'(val[0]);
  assign cnt_ext  = EW'(count_next);

  always_comb begin
    rsp_next.out_value  = '0;
    rsp_next.out_valid  = 1'b0;
    rsp_next.status     = spq_pkg::STATUS_OK;
    rsp_next.item_count = cnt_ext[CW-1:0];
    unique case (req.req_type)
      spq_pkg::REQ_ENQ: begin
        if (is_full) begin
          rsp_next.status = spq_pkg::STATUS_FULL;
        end
      end
      spq_pkg::REQ_DEQ: begin
        if (is_empty) begin
          rsp_next.status = spq_pkg::STATUS_EMPTY;
        end else begin
          rsp_next.out_value = head_ext[VW-1:0];
          rsp_next.out_valid = 1'b1;
        end
      end
      default: begin
        rsp_next.status = spq_pkg::STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  `SPQ_ASSERT_ALWAYS(a_head_matches_count, vld[0] == (count != '0), "head valid vs count")
  `SPQ_ASSERT_ALWAYS(a_tail_matches_full, vld[CAPACITY-1] == is_full, "tail valid vs full")
  `SPQ_ASSERT_ALWAYS(a_sorted_head, !vld[1] || (val[0] <= val[1]), "head not smallest")
  `SPQ_ASSERT_NEXT(a_deq_count, deq_ok, count == $past(count) - CNT_W'(1), "deq count")

endmodule

[design/spq_cell.sv]
// One cell of the sorted chain: holds a value and its valid bit.
// Depends on spq_pkg (spq_op_t).
`timescale 1ns / 1ps

module spq_cell #(
  parameter int VALUE_WIDTH = spq_pkg::SPQ_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  spq_pkg::spq_op_t       op,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic                   left_valid,
  input  logic                   left_take,
  input  logic [VALUE_WIDTH-1:0] right_value,
  input  logic                   right_valid,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   valid,
  output logic                   take
);

  // An empty cell counts as larger than anything, so take stays monotonic.
  assign take = !valid || (value >= new_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.enq && take) begin
      if (left_take) begin
        // shift up behind the insertion point
        valid <= left_valid;
      end else begin
        valid <= 1'b1;
      end
    end else if (op.deq) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.enq && take) begin
      value <= left_take ? left_value : new_value;
    end else if (op.deq) begin
      value <= right_value;
    end
  end

endmodule

[test/tb.sv]
// Testbench for sorted_priority_queue: random and directed enqueue/dequeue traffic.
// A shadow sorted list predicts each response item.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int PHASE_ITEMS    = 410;
  localparam int VALUE_W        = spq_pkg::FIELD_VALUE_W;
  localparam int COUNT_W        = spq_pkg::FIELD_COUNT_W;

  typedef enum int { BURST_FILL, BURST_DRAIN, BURST_MIXED } burst_mode_t;

  class sorted_queue_tracker;
    logic [VALUE_W-1:0]  shadow_values[$];
    spq_pkg::spq_rsp_t   expected_rsps[$];
    int                  errors;

    function new();
      errors = 0;
    endfunction

    // Apply one accepted request to the shadow list and queue its response.
    function void note_request(spq_pkg::spq_req_t item);
      spq_pkg::spq_rsp_t rsp_exp;
      int                pos;
      rsp_exp = '0;
      if (item.req_type == spq_pkg::REQ_ENQ) begin
        if (shadow_values.size() >= spq_pkg::SPQ_CAPACITY) begin
          rsp_exp.status = spq_pkg::STATUS_FULL;
        end else begin
          // New value goes ahead of any equal values already held.
          pos = shadow_values.size();
          for (int k = 0; k < shadow_values.size(); k++) begin
            if (shadow_values[k] >= item.in_value) begin
              pos = k;
              break;
            end
          end
          shadow_values.insert(pos, item.in_value);
          rsp_exp.status = spq_pkg::STATUS_OK;
        end
      end else begin
        if (shadow_values.size() == 0) begin
          rsp_exp.status = spq_pkg::STATUS_EMPTY;
        end else begin
          rsp_exp.out_value = shadow_values.pop_front();
          rsp_exp.out_valid = 1'b1;
          rsp_exp.status    = spq_pkg::STATUS_OK;
        end
      end
      rsp_exp.item_count = COUNT_W'(shadow_values.size());
      expected_rsps.push_back(rsp_exp);
    endfunction

    function void check_response(spq_pkg::spq_rsp_t got);
      spq_pkg::spq_rsp_t want;
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response item %h", $time, got);
        errors++;
        return;
      end
      want = expected_rsps.pop_front();
      if (got.out_value !== want.out_value) begin
        $display("%0t: out_value expected %h actual %h", $time, want.out_value, got.out_value);
        errors++;
      end
      if (got.out_valid !== want.out_valid) begin
        $display("%0t: out_valid expected %b actual %b", $time, want.out_valid, got.out_valid);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.item_count !== want.item_count) begin
        $display("%0t: item_count expected %0d actual %0d", $time, want.item_count,
                 got.item_count);
        errors++;
      end
    endfunction

    function int pending_count();
      return expected_rsps.size();
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  spq_pkg::spq_req_t req       = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  spq_pkg::spq_rsp_t rsp;

  sorted_queue_tracker sb;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int stuck_cycles  = 0;

  sorted_priority_queue uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_OFF_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, stuck_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(input spq_pkg::spq_req_t item);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // Drop valid and hold until every queued response item has come back.
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  function automatic spq_pkg::spq_req_t make_req(input logic kind, input logic [15:0] value);
    spq_pkg::spq_req_t item;
    item.req_type = kind;
    item.in_value = value;
    return item;
  endfunction

  function automatic logic [15:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return 16'($urandom_range(0, 7));
    if (roll < 40) return 16'hFFFF - 16'($urandom_range(0, 3));
    if (roll < 45) return 16'h8000;
    return 16'($urandom);
  endfunction

  function automatic spq_pkg::spq_req_t random_req(input burst_mode_t mode);
    int enq_pct;
    case (mode)
      BURST_FILL:  enq_pct = 85;
      BURST_DRAIN: enq_pct = 15;
      default:     enq_pct = 50;
    endcase
    if ($urandom_range(99) < enq_pct) return make_req(spq_pkg::REQ_ENQ, pick_value());
    return make_req(spq_pkg::REQ_DEQ, 16'($urandom));
  endfunction

  task automatic run_random(input int count);
    int          left;
    int          burst_len;
    burst_mode_t mode;
    left = count;
    while (left > 0) begin
      mode      = burst_mode_t'($urandom_range(0, 2));
      burst_len = $urandom_range(8, 40);
      for (int i = 0; i < burst_len && left > 0; i++) begin
        send_item(random_req(mode));
        left--;
      end
    end
  endtask

  initial begin
    logic [15:0] fill_vals [16];
    sb = new();
    fill_vals = '{16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                  16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE, 16'h1234, 16'h5555, 16'h00FF,
                  16'hFF00, 16'h8001};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty dequeue, fill with extremes and duplicates, overflow, then dequeues.
    send_item(make_req(spq_pkg::REQ_DEQ, 16'hFFFF));
    foreach (fill_vals[i]) send_item(make_req(spq_pkg::REQ_ENQ, fill_vals[i]));
    send_item(make_req(spq_pkg::REQ_ENQ, 16'h0000));
    send_item(make_req(spq_pkg::REQ_ENQ, 16'hFFFF));
    repeat (3) send_item(make_req(spq_pkg::REQ_DEQ, 16'h0000));
    wait_for_drain();

    send_idle_pct = 12;
    recv_idle_pct = 65;
    hold_requests = hold_requests + 1;
    run_random(PHASE_ITEMS);
    wait_for_drain();

    send_idle_pct = 65;
    recv_idle_pct = 12;
    run_random(PHASE_ITEMS);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);
    wait_for_drain();
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
